@@ src/bvdw_pkg.sv @@
// Shared types, constants and helper functions for the buffered vdW pair unit.
package bvdw_pkg;

    // Internal magnitudes use 32 fraction bits
    localparam logic [63:0] ONE_Q32 = 64'd1 << 32;
    localparam logic [63:0] K_107   = ((64'd107 << 32) + 64'd50) / 64'd100;
    localparam logic [63:0] K_007   = ((64'd7 << 32) + 64'd50) / 64'd100;
    localparam logic [63:0] K_112   = ((64'd112 << 32) + 64'd50) / 64'd100;
    localparam logic [63:0] K_012   = ((64'd12 << 32) + 64'd50) / 64'd100;
    localparam logic [63:0] K_784   = ((64'd784 << 32) + 64'd50) / 64'd100;
    localparam logic [63:0] K_14    = 64'd14 << 32;
    localparam logic [63:0] K_2     = 64'd2 << 32;
    localparam logic [63:0] K_001   = ((64'd1 << 32) + 64'd50) / 64'd100;
    localparam logic [63:0] SAT_MAX = {64{1'b1}};
    localparam int          P_FRAC  = 26;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    // One classified pair
    typedef struct packed {
        logic [23:0]        pair_distance;
        logic signed [23:0] delta_x;
        logic signed [23:0] delta_y;
        logic signed [23:0] delta_z;
        logic [23:0]        pair_radius;
        logic [19:0]        well_depth;
        logic               last_pair;
        logic               zero_dist;
    } t_item;

    // Front to back hand-over
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q2b;

    // Operation request to the arithmetic units
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        logic [5:0]  sh;
    } t_op;

    // Unit result
    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_res;

    // Clamp a magnitude with sign to a 40 bit two's complement value
    function automatic logic signed [39:0] sat40(input logic [63:0] mag, input logic neg);
        logic [63:0] lim;
        logic [63:0] m;
        begin
            lim = 64'd1 << 39;
            m   = mag;
            if (neg) begin
                if (m > lim) m = lim;
                sat40 = 40'(64'd0 - m);
            end else begin
                if (m > lim - 64'd1) m = lim - 64'd1;
                sat40 = 40'(m);
            end
        end
    endfunction

endpackage

@@ src/buffered_vdw_pair_energy_gradient_unit.sv @@
// Top level: buffered 14-7 van der Waals pair energy and gradient unit.
// Each pair with a non-zero distance takes eight divisions and twenty-two
// multiplications in turn; a zero distance replaces the gradient steps with a fixed
// push, and a saturating division skips the restoring steps. The pair rate is set
// mostly by the shared divider; the two-entry queue accepts further pairs while one
// is worked on.
// Reset: synchronous, active low; clears the queue, sequencer and energy sum.
module buffered_vdw_pair_energy_gradient_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [23:0]        i_pair_distance,
    input  logic signed [23:0] i_delta_x,
    input  logic signed [23:0] i_delta_y,
    input  logic signed [23:0] i_delta_z,
    input  logic [23:0]        i_pair_radius,
    input  logic [19:0]        i_well_depth,
    input  logic               i_last_pair,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [39:0] o_pair_energy,
    output logic signed [39:0] o_grad_x,
    output logic signed [39:0] o_grad_y,
    output logic signed [39:0] o_grad_z,
    output logic signed [47:0] o_energy_total,
    output logic               o_total_done
);

    bvdw_pkg::t_q2b q2b;
    logic pop;

    bvdw_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_pair_distance(i_pair_distance), .i_delta_x(i_delta_x),
        .i_delta_y(i_delta_y), .i_delta_z(i_delta_z),
        .i_pair_radius(i_pair_radius), .i_well_depth(i_well_depth),
        .i_last_pair(i_last_pair), .i_pop(pop), .o_q2b(q2b)
    );

    bvdw_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q2b(q2b), .o_pop(pop),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_pair_energy(o_pair_energy), .o_grad_x(o_grad_x), .o_grad_y(o_grad_y),
        .o_grad_z(o_grad_z), .o_energy_total(o_energy_total),
        .o_total_done(o_total_done)
    );

endmodule

@@ src/bvdw_front.sv @@
// Front end: accepts pairs, classifies them and queues them for the back end.
module bvdw_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [23:0]           i_pair_distance,
    input  logic signed [23:0]    i_delta_x,
    input  logic signed [23:0]    i_delta_y,
    input  logic signed [23:0]    i_delta_z,
    input  logic [23:0]           i_pair_radius,
    input  logic [19:0]           i_well_depth,
    input  logic                  i_last_pair,
    input  logic                  i_pop,
    output bvdw_pkg::t_q2b        o_q2b
);

    bvdw_pkg::t_item r_q [bvdw_pkg::QDEPTH];
    logic [bvdw_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [bvdw_pkg::QPTR_W:0]   r_cnt;
    bvdw_pkg::t_item n_item;
    logic push, pop;

    // Classify: zero radius becomes one LSB, flag zero distance
    always_comb begin
        n_item.pair_distance = i_pair_distance;
        n_item.delta_x       = i_delta_x;
        n_item.delta_y       = i_delta_y;
        n_item.delta_z       = i_delta_z;
        n_item.pair_radius   = (i_pair_radius == 24'd0) ? 24'd1 : i_pair_radius;
        n_item.well_depth    = i_well_depth;
        n_item.last_pair     = i_last_pair;
        n_item.zero_dist     = (i_pair_distance == 24'd0);
    end

    assign o_stall = (r_cnt == (bvdw_pkg::QPTR_W+1)'(bvdw_pkg::QDEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_cnt != '0);

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_item;
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (bvdw_pkg::QPTR_W+1)'(push) - (bvdw_pkg::QPTR_W+1)'(pop);
        end
    end

    assign o_q2b.valid = (r_cnt != '0);
    assign o_q2b.item  = r_q[r_rp];

endmodule

@@ src/bvdw_div.sv @@
// Restoring divider, (a << 32) / b, one quotient bit per cycle, saturating.
module bvdw_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bvdw_pkg::t_op  i_op,
    output bvdw_pkg::t_res o_res
);

    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_hi, r_lq, r_b, r_res;
    logic [64:0] trial;
    logic        take;

    // One restoring step
    assign trial = {r_hi, r_lq[63]};
    assign take  = (trial >= {1'b0, r_b});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_op.start) begin
                if (i_op.b == 64'd0 || {32'd0, i_op.a[63:32]} >= i_op.b) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_op.start) begin
            r_hi  <= {32'd0, i_op.a[63:32]};
            r_lq  <= {i_op.a[31:0], 32'd0};
            r_b   <= i_op.b;
            r_res <= bvdw_pkg::SAT_MAX;
        end else if (r_busy) begin
            r_hi <= take ? 64'(trial - {1'b0, r_b}) : trial[63:0];
            r_lq <= {r_lq[62:0], take};
            if (r_cnt == 6'd63) r_res <= {r_lq[62:0], take};
        end
    end

    assign o_res.done = r_done;
    assign o_res.res  = r_res;

endmodule

@@ src/bvdw_mul.sv @@
// 64x64 multiplier from four 32x32 partial products, then shift right and saturate.
module bvdw_mul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bvdw_pkg::t_op  i_op,
    output bvdw_pkg::t_res o_res
);

    logic         r_busy, r_fin, r_done;
    logic [1:0]   r_cnt;
    logic [63:0]  r_a, r_b, r_res;
    logic [5:0]   r_sh;
    logic [127:0] r_acc;
    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh, shifted;

    // Partial product select
    always_comb begin
        pa = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        pb = r_cnt[0] ? r_b[63:32] : r_b[31:0];
        pp = pa * pb;
        case (r_cnt)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        shifted = r_acc >> r_sh;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_op.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_op.start) begin
            r_a   <= i_op.a;
            r_b   <= i_op.b;
            r_sh  <= i_op.sh;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + pp_sh;
        end
        if (r_fin) r_res <= (|shifted[127:64]) ? bvdw_pkg::SAT_MAX : shifted[63:0];
    end

    assign o_res.done = r_done;
    assign o_res.res  = r_res;

endmodule

@@ src/bvdw_back.sv @@
// Back end: sequences one pair through the shared divider and multiplier.
module bvdw_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bvdw_pkg::t_q2b         i_q2b,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [39:0]     o_pair_energy,
    output logic signed [39:0]     o_grad_x,
    output logic signed [39:0]     o_grad_y,
    output logic signed [39:0]     o_grad_z,
    output logic signed [47:0]     o_energy_total,
    output logic                   o_total_done
);

    localparam logic [5:0] GSH = 6'(40 + bvdw_pkg::P_FRAC - FRAC_BITS);
    localparam logic [5:0] PSH = 6'(64 - bvdw_pkg::P_FRAC);

    // Step codes
    localparam logic [4:0] S_Q   = 5'd0;
    localparam logic [4:0] S_T   = 5'd1;
    localparam logic [4:0] S_T2  = 5'd2;
    localparam logic [4:0] S_T4  = 5'd3;
    localparam logic [4:0] S_T6  = 5'd4;
    localparam logic [4:0] S_T7  = 5'd5;
    localparam logic [4:0] S_Q2  = 5'd6;
    localparam logic [4:0] S_Q4  = 5'd7;
    localparam logic [4:0] S_Q6  = 5'd8;
    localparam logic [4:0] S_Q7  = 5'd9;
    localparam logic [4:0] S_S   = 5'd10;
    localparam logic [4:0] S_B1  = 5'd11;
    localparam logic [4:0] S_TB  = 5'd12;
    localparam logic [4:0] S_E   = 5'd13;
    localparam logic [4:0] S_G0  = 5'd14;
    localparam logic [4:0] S_A   = 5'd15;
    localparam logic [4:0] S_B   = 5'd16;
    localparam logic [4:0] S_C   = 5'd17;
    localparam logic [4:0] S_D   = 5'd18;
    localparam logic [4:0] S_F   = 5'd19;
    localparam logic [4:0] S_P   = 5'd20;
    localparam logic [4:0] S_FD  = 5'd21;
    localparam logic [4:0] S_R   = 5'd22;
    localparam logic [4:0] S_PR  = 5'd23;
    localparam logic [4:0] S_G   = 5'd24;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    t_state r_state;
    logic [4:0] r_step;
    logic [1:0] r_axis;
    bvdw_pkg::t_item r_item;
    logic [63:0] r_q, r_u, r_t, r_t2, r_t7, r_x, r_y, r_q6, r_s;
    logic r_bneg, r_aneg, r_brneg;
    logic signed [39:0] r_energy;
    logic signed [39:0] r_g [3];
    logic signed [47:0] r_acc;

    bvdw_pkg::t_op  mul_op, div_op;
    bvdw_pkg::t_res mul_res, div_res;
    logic        unit_done;
    logic [63:0] res;
    logic [23:0] dsel;
    logic        dneg;
    logic [24:0] dmag;
    logic [63:0] term2, br, sum_v;
    logic signed [48:0] sum_w;
    logic signed [47:0] sum;
    logic out_free;

    bvdw_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(div_op), .o_res(div_res));
    bvdw_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(mul_op), .o_res(mul_res));

    assign unit_done = div_res.done || mul_res.done;
    assign res       = div_res.done ? div_res.res : mul_res.res;
    assign out_free  = !o_valid || !i_stall;
    assign o_pop     = (r_state == ST_IDLE) && i_q2b.valid;

    // Displacement magnitude of the current axis, plus helper terms and the clamped running sum
    always_comb begin
        case (r_axis)
            2'd0:    dsel = r_item.delta_x;
            2'd1:    dsel = r_item.delta_y;
            default: dsel = r_item.delta_z;
        endcase
        dneg  = dsel[23];
        dmag  = dneg ? (25'h1000000 - {1'b0, dsel}) : {1'b0, dsel};
        term2 = r_aneg ? (64'd0 - res) : res;
        br    = term2 - r_y;
        sum_v = (res > bvdw_pkg::SAT_MAX - bvdw_pkg::K_012) ? bvdw_pkg::SAT_MAX
                                                           : res + bvdw_pkg::K_012;
        sum_w = {r_acc[47], r_acc} + 49'(r_energy);
        if (sum_w > 49'sh0_7FFF_FFFF_FFFF)       sum = 48'sh7FFF_FFFF_FFFF;
        else if (sum_w < -49'sh0_8000_0000_0000) sum = 48'sh8000_0000_0000;
        else                                     sum = sum_w[47:0];
    end

    // Operand selection per step
    always_comb begin
        mul_op = '0;
        div_op = '0;
        mul_op.sh = 6'd32;
        if (r_state == ST_ISSUE) begin
            case (r_step)
                S_Q:  begin div_op.start = 1'b1;
                      div_op.a = 64'(r_item.pair_distance);
                      div_op.b = 64'(r_item.pair_radius); end
                S_T:  begin div_op.start = 1'b1; div_op.a = bvdw_pkg::K_107; div_op.b = r_u; end
                S_T2: begin mul_op.start = 1'b1; mul_op.a = r_t;  mul_op.b = r_t; end
                S_T4: begin mul_op.start = 1'b1; mul_op.a = r_t2; mul_op.b = r_t2; end
                S_T6: begin mul_op.start = 1'b1; mul_op.a = r_x;  mul_op.b = r_t2; end
                S_T7: begin mul_op.start = 1'b1; mul_op.a = r_x;  mul_op.b = r_t; end
                S_Q2: begin mul_op.start = 1'b1; mul_op.a = r_q;  mul_op.b = r_q; end
                S_Q4: begin mul_op.start = 1'b1; mul_op.a = r_y;  mul_op.b = r_y; end
                S_Q6: begin mul_op.start = 1'b1; mul_op.a = r_x;  mul_op.b = r_y; end
                S_Q7: begin mul_op.start = 1'b1; mul_op.a = r_q6; mul_op.b = r_q; end
                S_S:  begin div_op.start = 1'b1; div_op.a = bvdw_pkg::ONE_Q32; div_op.b = r_x; end
                S_B1: begin mul_op.start = 1'b1; mul_op.a = bvdw_pkg::K_112; mul_op.b = r_s; end
                S_TB: begin mul_op.start = 1'b1; mul_op.a = r_t7; mul_op.b = r_x; end
                S_E:  begin mul_op.start = 1'b1;
                      mul_op.a = 64'(r_item.well_depth); mul_op.b = r_x; end
                S_G0: begin mul_op.start = 1'b1;
                      mul_op.a = 64'(r_item.pair_radius); mul_op.b = bvdw_pkg::K_001; end
                S_A:  begin mul_op.start = 1'b1; mul_op.a = r_q6; mul_op.b = r_s; end
                S_B:  begin mul_op.start = 1'b1; mul_op.a = bvdw_pkg::K_784; mul_op.b = r_x; end
                S_C:  begin mul_op.start = 1'b1; mul_op.a = r_x;  mul_op.b = r_s; end
                S_D:  begin mul_op.start = 1'b1; mul_op.a = bvdw_pkg::K_784; mul_op.b = r_s; end
                S_F:  begin div_op.start = 1'b1; div_op.a = r_x; div_op.b = r_u; end
                S_P:  begin mul_op.start = 1'b1; mul_op.a = r_t7; mul_op.b = r_x;
                      mul_op.sh = PSH; end
                S_FD: begin div_op.start = 1'b1;
                      div_op.a = {36'd0, r_item.well_depth, 8'd0};
                      div_op.b = 64'(r_item.pair_radius); end
                S_R:  begin div_op.start = 1'b1; div_op.a = 64'(dmag);
                      div_op.b = 64'(r_item.pair_distance); end
                S_PR: begin mul_op.start = 1'b1; mul_op.a = r_y; mul_op.b = r_x; end
                S_G:  begin mul_op.start = 1'b1; mul_op.a = r_t; mul_op.b = r_x;
                      mul_op.sh = GSH; end
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= S_Q;
            r_axis  <= '0;
            r_acc   <= '0;
            o_valid <= 1'b0;
        end else begin
            // Result valid: set when a result is loaded, cleared once taken
            if (r_state == ST_OUT && out_free) o_valid <= 1'b1;
            else if (!i_stall)                 o_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_q2b.valid) begin
                        r_state <= ST_ISSUE;
                        r_step  <= S_Q;
                        r_axis  <= '0;
                    end
                end
                ST_ISSUE: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (unit_done) begin
                        case (r_step)
                            S_E: begin
                                r_state <= ST_ISSUE;
                                r_step  <= r_item.zero_dist ? S_G0 : S_A;
                            end
                            S_G0: r_state <= ST_OUT;
                            S_G: begin
                                if (r_axis == 2'd2) begin
                                    r_state <= ST_OUT;
                                end else begin
                                    r_state <= ST_ISSUE;
                                    r_axis  <= r_axis + 2'd1;
                                    r_step  <= S_R;
                                end
                            end
                            default: begin
                                r_state <= ST_ISSUE;
                                r_step  <= r_step + 5'd1;
                            end
                        endcase
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_acc   <= r_item.last_pair ? 48'sd0 : sum;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Item latch and working registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_q2b.valid) r_item <= i_q2b.item;
        if (r_state == ST_WAIT && unit_done) begin
            case (r_step)
                S_Q:  begin r_q <= res; r_u <= res + bvdw_pkg::K_007; end
                S_T:  r_t  <= res;
                S_T2: r_t2 <= res;
                S_T4: r_x  <= res;
                S_T6: r_x  <= res;
                S_T7: r_t7 <= res;
                S_Q2: r_y  <= res;
                S_Q4: r_x  <= res;
                S_Q6: r_q6 <= res;
                S_Q7: r_x  <= sum_v;
                S_S:  r_s  <= res;
                S_B1: begin
                    r_bneg <= res < bvdw_pkg::K_2;
                    r_x    <= (res < bvdw_pkg::K_2) ? bvdw_pkg::K_2 - res : res - bvdw_pkg::K_2;
                end
                S_TB: r_x <= res;
                S_E:  r_energy <= bvdw_pkg::sat40(res, r_bneg);
                S_G0: begin
                    r_g[0] <= bvdw_pkg::sat40(res, 1'b0);
                    r_g[1] <= bvdw_pkg::sat40(res, 1'b0);
                    r_g[2] <= bvdw_pkg::sat40(res, 1'b0);
                end
                S_A:  r_x <= res;
                S_B:  r_x <= res;
                S_C:  r_y <= res;
                S_D: begin
                    r_aneg <= res > bvdw_pkg::K_14;
                    r_x    <= (res > bvdw_pkg::K_14) ? res - bvdw_pkg::K_14 : bvdw_pkg::K_14 - res;
                end
                S_F: begin
                    r_brneg <= br[63];
                    r_x     <= br[63] ? (64'd0 - br) : br;
                end
                S_P:  r_y <= res;
                S_FD: r_t <= res;
                S_R:  r_x <= res;
                S_PR: r_x <= res;
                S_G:  r_g[r_axis] <= bvdw_pkg::sat40(res, r_brneg ^ dneg);
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            o_pair_energy  <= r_energy;
            o_grad_x       <= r_g[0];
            o_grad_y       <= r_g[1];
            o_grad_z       <= r_g[2];
            o_energy_total <= sum;
            o_total_done   <= r_item.last_pair;
        end
    end

endmodule

@@ verif/tb_buffered_vdw_pair_energy_gradient_unit.sv @@
// Testbench for the buffered 14-7 vdW pair energy and gradient unit.
`timescale 1ns / 100ps

// Scoreboard: bit-true prediction of each pair and an in-order check of results
class vdw_scoreboard;

    typedef struct {
        logic signed [39:0] energy;
        logic signed [39:0] gx;
        logic signed [39:0] gy;
        logic signed [39:0] gz;
        logic signed [47:0] total;
        logic               done;
    } t_vdw_result;

    t_vdw_result pending[$];
    longint      energy_sum;
    int          mismatches;
    int          results_seen;

    function new();
        energy_sum   = 0;
        mismatches   = 0;
        results_seen = 0;
    endfunction

    // (a*b) >> sh over the full product, saturating at all ones
    static function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> sh;
        if (p[127:64] != 0) return '1;
        return p[63:0];
    endfunction

    static function logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        return mul_shift(a, b, 32);
    endfunction

    // (a << 32) / b, truncated, saturating
    static function logic [63:0] qdiv(logic [63:0] a, logic [63:0] b);
        logic [127:0] n;
        if (b == 0 || (a >> 32) >= b) return '1;
        n = {32'd0, a, 32'd0};
        return 64'(n / {64'd0, b});
    endfunction

    // Signed clamp of a magnitude to the given width
    static function longint clamp(logic [63:0] mag, bit neg, int bits);
        logic [63:0] lim;
        lim = 64'd1 << (bits - 1);
        if (neg) begin
            if (mag > lim) mag = lim;
            return -longint'(mag);
        end
        if (mag > lim - 1) mag = lim - 1;
        return longint'(mag);
    endfunction

    // Work out the result of one accepted pair transaction
    function void note_pair(logic [23:0] pair_dist, logic [23:0] dx, logic [23:0] dy,
                            logic [23:0] dz, logic [23:0] radius,
                            logic [19:0] depth, logic last);
        logic [63:0] d, rad, eps, q, u, t, t2, t4, t7, q2, q4, q6, q7, v, s;
        logic [63:0] b1, bmag, emag, term1, c, amag, t2mag, brmag, pmag, f;
        logic [63:0] raw, dmag, r, pr, gmag;
        logic [23:0] deltas[3];
        bit          bneg, aneg, brneg, dneg;
        longint      energy, sum, term2, br;
        longint      grad[3];
        t_vdw_result exp_res;
        d   = pair_dist;
        rad = (radius == 0) ? 64'd1 : 64'(radius);
        eps = depth;
        deltas[0] = dx;
        deltas[1] = dy;
        deltas[2] = dz;

        q  = qdiv(d, rad);
        u  = q + bvdw_pkg::K_007;
        t  = qdiv(bvdw_pkg::K_107, u);
        t2 = qmul(t, t);
        t4 = qmul(t2, t2);
        t7 = qmul(qmul(t4, t2), t);
        q2 = qmul(q, q);
        q4 = qmul(q2, q2);
        q6 = qmul(q4, q2);
        q7 = qmul(q6, q);
        v  = (q7 > bvdw_pkg::SAT_MAX - bvdw_pkg::K_012) ? bvdw_pkg::SAT_MAX
                                                       : q7 + bvdw_pkg::K_012;
        s  = qdiv(bvdw_pkg::ONE_Q32, v);

        // Energy: eps * t^7 * (1.12 s - 2)
        b1     = qmul(bvdw_pkg::K_112, s);
        bneg   = b1 < bvdw_pkg::K_2;
        bmag   = bneg ? bvdw_pkg::K_2 - b1 : b1 - bvdw_pkg::K_2;
        emag   = mul_shift(eps, qmul(t7, bmag), 32);
        energy = clamp(emag, bneg, 40);

        if (d == 0) begin
            // coincident atoms: fixed push of R* * 0.01 on every axis
            grad[0] = clamp(mul_shift(rad, bvdw_pkg::K_001, 32), 1'b0, 40);
            grad[1] = grad[0];
            grad[2] = grad[0];
        end else begin
            term1 = qmul(qmul(bvdw_pkg::K_784, qmul(q6, s)), s);
            c     = qmul(bvdw_pkg::K_784, s);
            aneg  = c > bvdw_pkg::K_14;
            amag  = aneg ? c - bvdw_pkg::K_14 : bvdw_pkg::K_14 - c;
            t2mag = qdiv(amag, u);
            term2 = aneg ? -longint'(t2mag) : longint'(t2mag);
            br    = term2 - longint'(term1);
            brneg = br < 0;
            brmag = brneg ? 64'(-br) : 64'(br);
            pmag  = mul_shift(t7, brmag, 64 - bvdw_pkg::P_FRAC);
            f     = (eps << 40) / rad;
            for (int k = 0; k < 3; k++) begin
                raw     = deltas[k];
                dneg    = raw[23];
                dmag    = dneg ? 64'h1000000 - raw : raw;
                r       = qdiv(dmag, d);
                pr      = mul_shift(pmag, r, 32);
                gmag    = mul_shift(f, pr, 40 + bvdw_pkg::P_FRAC - 16);
                grad[k] = clamp(gmag, brneg != dneg, 40);
            end
        end

        // Running sum, clamped to 48 bits, cleared after the last pair
        sum = energy_sum + energy;
        if (sum > (64'sd1 <<< 47) - 1) sum = (64'sd1 <<< 47) - 1;
        if (sum < -(64'sd1 <<< 47))    sum = -(64'sd1 <<< 47);
        energy_sum = last ? 0 : sum;

        exp_res.energy = energy[39:0];
        exp_res.gx     = grad[0][39:0];
        exp_res.gy     = grad[1][39:0];
        exp_res.gz     = grad[2][39:0];
        exp_res.total  = sum[47:0];
        exp_res.done   = last;
        pending = {pending, exp_res};
    endfunction

    // Compare one accepted result transaction with the oldest prediction
    function void check_result(logic signed [39:0] energy, logic signed [39:0] gx,
                               logic signed [39:0] gy, logic signed [39:0] gz,
                               logic signed [47:0] total, logic done);
        t_vdw_result e;
        results_seen++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result transaction %0d", results_seen);
            return;
        end
        e = pending.pop_front();
        if (energy !== e.energy || gx !== e.gx || gy !== e.gy || gz !== e.gz ||
            total !== e.total || done !== e.done) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d mismatch", results_seen);
                $display("  exp E=%0d g=(%0d,%0d,%0d) sum=%0d last=%0b",
                         e.energy, e.gx, e.gy, e.gz, e.total, e.done);
                $display("  got E=%0d g=(%0d,%0d,%0d) sum=%0d last=%0b",
                         energy, gx, gy, gz, total, done);
            end
        end
    endfunction

endclass

module tb_buffered_vdw_pair_energy_gradient_unit;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [23:0]        i_pair_distance;
    logic signed [23:0] i_delta_x;
    logic signed [23:0] i_delta_y;
    logic signed [23:0] i_delta_z;
    logic [23:0]        i_pair_radius;
    logic [19:0]        i_well_depth;
    logic               i_last_pair;
    logic               o_valid;
    logic               i_stall;
    logic signed [39:0] o_pair_energy;
    logic signed [39:0] o_grad_x;
    logic signed [39:0] o_grad_y;
    logic signed [39:0] o_grad_z;
    logic signed [47:0] o_energy_total;
    logic               o_total_done;

    vdw_scoreboard sb;
    int            burst_left;
    bit            long_hold_done;

    buffered_vdw_pair_energy_gradient_unit dut (.*);

    // 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Results are sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_pair_energy, o_grad_x, o_grad_y, o_grad_z,
                            o_energy_total, o_total_done);
    end

    // Offer one pair and hold it until accepted; gaps fall between bursts
    task automatic send_pair(logic [23:0] pair_dist, logic [23:0] dx, logic [23:0] dy,
                             logic [23:0] dz, logic [23:0] radius,
                             logic [19:0] depth, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        i_pair_distance = pair_dist;
        i_delta_x       = dx;
        i_delta_y       = dy;
        i_delta_z       = dz;
        i_pair_radius   = radius;
        i_well_depth    = depth;
        i_last_pair     = last;
        i_valid         = 1'b1;
        do
            @(posedge i_clk);
        while (o_stall);
        sb.note_pair(pair_dist, dx, dy, dz, radius, depth, last);
        burst_left--;
        @(negedge i_clk);
    endtask

    // Physically sensible pair: R* of 2..5 A, q of about 0.3..3, delta below r
    task automatic send_sensible_pair();
        logic [23:0] radius, pair_dist;
        logic [23:0] dv[3];
        radius    = 24'($urandom_range(2 << 16, 5 << 16));
        pair_dist = 24'((longint'(radius) * $urandom_range(300, 3000)) / 1000);
        for (int k = 0; k < 3; k++) begin
            dv[k] = 24'($urandom_range(0, pair_dist / 2));
            if ($urandom_range(0, 1)) dv[k] = -dv[k];
        end
        send_pair(pair_dist, dv[0], dv[1], dv[2], radius,
                  20'($urandom_range(0, 1 << 16)), $urandom_range(0, 7) == 0);
    endtask

    // Receiver: stall pattern of its own, one long hold-off to fill the block
    initial begin
        int mode_len;
        bit busy;
        i_stall = 1'b0;
        forever begin
            mode_len = $urandom_range(50, 2000);
            busy     = $urandom_range(0, 1);
            repeat (mode_len) begin
                @(negedge i_clk);
                if (!long_hold_done && sb != null && sb.results_seen >= 40) begin
                    long_hold_done = 1'b1;
                    i_stall = 1'b1;
                    repeat (3000) @(negedge i_clk);
                end
                i_stall = busy ? ($urandom_range(0, 2) != 0) : 1'b0;
            end
        end
    end

    // Watchdog
    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    // Main sequence
    initial begin
        int waited;
        sb = new();
        burst_left      = 0;
        long_hold_done  = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_pair_distance = '0;
        i_delta_x       = '0;
        i_delta_y       = '0;
        i_delta_z       = '0;
        i_pair_radius   = 24'd1;
        i_well_depth    = '0;
        i_last_pair     = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zero distance, field extremes, saturation, list ends
        send_pair(24'd0, 24'd0, 24'd0, 24'd0, 24'h030000, 20'h10000, 1'b0);
        send_pair(24'd0, 24'h7FFFFF, 24'h800000, 24'd1, 24'hFFFFFF, 20'hFFFFF, 1'b1);
        send_pair(24'h038000, 24'h020000, 24'hFE0000, 24'h010000, 24'h038000,
                  20'h10000, 1'b0);
        send_pair(24'h038000, 24'h020000, 24'hFE0000, 24'h010000, 24'h038000,
                  20'd0, 1'b0);
        send_pair(24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'd1,
                  20'hFFFFF, 1'b0);
        send_pair(24'd1, 24'h7FFFFF, 24'h800000, 24'd1, 24'hFFFFFF, 20'hFFFFF, 1'b0);
        send_pair(24'd1, 24'd1, 24'hFFFFFF, 24'd0, 24'd1, 20'hFFFFF, 1'b1);
        send_pair(24'h010000, 24'h7FFFFF, 24'h800000, 24'h000001, 24'h040000,
                  20'h80000, 1'b0);
        send_pair(24'h008000, 24'h004000, 24'hFFC000, 24'd0, 24'h040000,
                  20'hFFFFF, 1'b0);
        send_pair(24'hFFFFFF, 24'h555555, 24'hAAAAAA, 24'h0F0F0F, 24'hFFFFFF,
                  20'h5A5A5, 1'b1);
        for (int n = 0; n < 8; n++)
            send_pair(24'h040000, 24'h020000, 24'h020000, 24'h020000, 24'h020000,
                      20'hFFFFF, 1'b0);
        send_pair(24'h0C0000, 24'h060000, 24'hFA0000, 24'h060000, 24'h030000,
                  20'h20000, 1'b1);

        // Random: mostly sensible pairs, the rest raw noise over all bits
        for (int n = 0; n < 730; n++) begin
            if ($urandom_range(0, 4) != 0)
                send_sensible_pair();
            else
                send_pair(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom_range(1, 24'hFFFFFF)), 20'($urandom),
                          1'($urandom));
        end
        i_valid = 1'b0;

        // Drain, then let the pipeline settle
        waited = 0;
        while (sb.pending.size() != 0 && waited < 2_000_000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (800) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
